// ----- src/svt_pkg.sv -----
`timescale 1ns / 1ps

package svt_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned PortW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned PidW  = 32;

  // Lookup key of one sender.
  typedef struct packed {
    logic [AddrW-1:0] source;
    logic [AddrW-1:0] group;
    logic [PortW-1:0] port;
  } key_t;

  // One table word as it is held in the RAM.
  typedef struct packed {
    key_t             key;
    logic             enabled;
    logic [TimeW-1:0] seen_time;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // One request as latched by the sequencer.
  typedef struct packed {
    key_t             key;
    logic             redundant;
    logic [TimeW-1:0] now;
    logic [PidW-1:0]  pid;
  } req_t;

  // Verdict flags handed from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    logic drop;
    logic created;
    logic full;
  } res_t;

endpackage

// ----- src/sender_table_verdict.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      source/group address, port, path flag,
//                                                time, packet id
// verdict   out        result_valid_o, 1 cycle   packet id, drop, created, table full
//
// A request is searched against the table one stored entry per cycle through a
// single key comparator fed by the registered read port of the table RAM.
// The search stops at the first entry whose key matches, or after the last valid
// entry; the verdict is then formed in the update state and registered for output.
// Reset empties the table at once by clearing the fill count; no sweep is run.
// The verdict is shown for one cycle only, as the receiver cannot stall it, and
// a new request may be accepted in that same cycle.

module sender_table_verdict
  import svt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_address_i,
  input  logic [31:0] group_address_i,
  input  logic [15:0] destination_port_i,
  input  logic        redundant_path_i,
  input  logic [31:0] current_time_i,
  input  logic [31:0] packet_id_i,
  output logic        result_valid_o,
  output logic [31:0] verdict_packet_id_o,
  output logic        verdict_drop_o,
  output logic        entry_created_o,
  output logic        table_full_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  req_t            req;
  res_t            res;
  logic [PidW-1:0] res_pid;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  entry_t          ram_rdata;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;

  logic            valid_q;
  logic            drop_q;
  logic            created_q;
  logic            full_q;
  logic [PidW-1:0] pid_q;

  // The packet fields are gathered into one request word for the sequencer.
  assign req.key.source = source_address_i;
  assign req.key.group  = group_address_i;
  assign req.key.port   = destination_port_i;
  assign req.redundant  = redundant_path_i;
  assign req.now        = current_time_i;
  assign req.pid        = packet_id_i;

  // The sequencer owns the search, the hit bookkeeping and the table update.
  svt_seq #(
    .TableEntries(TABLE_ENTRIES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req),
    .busy_o     (busy),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .res_o      (res),
    .res_pid_o  (res_pid)
  );

  // One word per sender: key, enabled mark and last-seen time.
  svt_ram #(
    .Width(EntryW),
    .Depth(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // The verdict is registered so that the sequencer is free again while it is
  // on the output ports.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      drop_q    <= res.drop;
      created_q <= res.created;
      full_q    <= res.full;
      pid_q     <= res_pid;
    end
  end

  assign result_valid_o      = valid_q;
  assign verdict_packet_id_o = pid_q;
  assign verdict_drop_o      = drop_q;
  assign entry_created_o     = created_q;
  assign table_full_o        = full_q;

endmodule

// ----- src/svt_ram.sv -----
`timescale 1ns / 1ps

module svt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/svt_seq.sv -----
`timescale 1ns / 1ps

module svt_seq
  import svt_pkg::*;
#(
  parameter int unsigned TableEntries = 64,
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1,
  localparam int unsigned CntW = $clog2(TableEntries + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  req_t            req_i,
  output logic            busy_o,
  output logic            ram_re_o,
  output logic [IdxW-1:0] ram_raddr_o,
  input  entry_t          ram_rdata_i,
  output logic            ram_we_o,
  output logic [IdxW-1:0] ram_waddr_o,
  output entry_t          ram_wdata_o,
  output res_t            res_o,
  output logic [PidW-1:0] res_pid_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  localparam logic [CntW-1:0] Capacity = CntW'(TableEntries);

  logic [1:0]      state_q, state_d;
  req_t            req_q, req_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            en_old_q, en_old_d;
  logic            more;
  logic            match;

  // Entries are filled from slot 0 upward and never removed, so slots below
  // the fill count are exactly the valid ones.
  assign more  = (idx_q != count_q);
  assign match = pend_q && (ram_rdata_i.key == req_q.key);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    count_d     = count_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    en_old_d    = en_old_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q[IdxW-1:0];
    ram_we_o    = 1'b0;
    ram_waddr_o = hit_idx_q;
    ram_wdata_o = '0;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = pend_idx_q;
          en_old_d  = ram_rdata_i.enabled;
          state_d   = S_UPD;
        end else if (more) begin
          ram_re_o   = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IdxW-1:0];
          idx_d      = idx_q + 1'b1;
        end else begin
          hit_d   = 1'b0;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        res_o.valid               = 1'b1;
        ram_wdata_o.key           = req_q.key;
        ram_wdata_o.seen_time     = req_q.now;
        if (hit_q) begin
          ram_we_o            = 1'b1;
          ram_waddr_o         = hit_idx_q;
          ram_wdata_o.enabled = en_old_q | req_q.redundant;
          res_o.drop          = !req_q.redundant && en_old_q;
        end else if (count_q != Capacity) begin
          ram_we_o            = 1'b1;
          ram_waddr_o         = count_q[IdxW-1:0];
          ram_wdata_o.enabled = req_q.redundant;
          count_d             = count_q + 1'b1;
          res_o.created       = 1'b1;
        end else begin
          res_o.full = 1'b1;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o    = (state_q != S_IDLE);
  assign res_pid_o = req_q.pid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    en_old_q   <= en_old_d;
  end

endmodule

// ----- src/svt_checker.sv -----
`timescale 1ns / 1ps

module svt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic verdict_drop_o,
  input logic entry_created_o,
  input logic table_full_o
);

  // Each request passes through scan and update, so verdict strobes never touch.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("verdict strobes in consecutive cycles");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_verdict_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy fell without a verdict");

  // A new or missing entry always means accept, and both flags never coincide.
  a_flag_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(verdict_drop_o && (entry_created_o || table_full_o)) &&
                       !(entry_created_o && table_full_o))
    else $error("inconsistent verdict flags");

endmodule

bind sender_table_verdict svt_checker u_svt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .verdict_drop_o (verdict_drop_o),
  .entry_created_o(entry_created_o),
  .table_full_o   (table_full_o)
);

// ----- tb/tb_sender_table_verdict.sv -----
`timescale 1ns / 1ps

// Checks the sender table verdict unit against a predictor of its own.
// A short directed table comes first: an empty table, keys at the extremes of
// every field, keys that differ from a stored one in a single field, and the
// enable mark being set by a redundant-path request and then causing drops.
// Random requests follow in several phases of sender idling. Most of them
// reuse keys already in the table, so that hits and the drop rule are
// exercised all the time, while a steady trickle of fresh keys fills the table
// and then runs into the table-full case. Verdicts cannot be stalled, so they
// are checked on the edge that ends their strobe cycle.

module tb_sender_table_verdict;
  import svt_pkg::*;

  localparam int unsigned Slots       = 64;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned NewKeyPct   = 12;
  localparam int unsigned LongestGap  = 2 * Slots + 10;
  localparam int unsigned DrainCycles = Slots + 16;
  // Cycles with neither a request taken nor a verdict shown. The slowest
  // correct request plus the longest sender gap stays far below this.
  localparam int unsigned StallLimit  = 4000;

  typedef struct packed {
    logic [PidW-1:0] pid;
    logic            drop;
    logic            created;
    logic            full;
  } verdict_t;

  // One row of the directed table. Where typed is set, the verdict is written
  // out by hand; otherwise it comes from the predictor.
  typedef struct packed {
    key_t             key;
    logic             redundant;
    logic [TimeW-1:0] now;
    logic [PidW-1:0]  pid;
    logic             typed;
    verdict_t         verdict;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [31:0]      source_address_i;
  logic [31:0]      group_address_i;
  logic [15:0]      destination_port_i;
  logic             redundant_path_i;
  logic [31:0]      current_time_i;
  logic [31:0]      packet_id_i;
  logic             result_valid_o;
  logic [31:0]      verdict_packet_id_o;
  logic             verdict_drop_o;
  logic             entry_created_o;
  logic             table_full_o;

  // Predictor copy of the sender table. Entries are never removed and a new
  // one always takes the lowest free slot, so the valid entries are always
  // slots 0 to sender_count - 1.
  logic             sender_valid   [Slots];
  key_t             sender_key     [Slots];
  logic             sender_enabled [Slots];
  logic [TimeW-1:0] sender_seen    [Slots];
  int unsigned      sender_count;

  verdict_t         pending_verdicts [$];
  stim_row_t        directed_rows    [$];
  int unsigned      fault_count = 0;
  int unsigned      quiet_cycles;
  int unsigned      phase_idle_pct;

  sender_table_verdict #(
    .TABLE_ENTRIES(Slots)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .source_address_i   (source_address_i),
    .group_address_i    (group_address_i),
    .destination_port_i (destination_port_i),
    .redundant_path_i   (redundant_path_i),
    .current_time_i     (current_time_i),
    .packet_id_i        (packet_id_i),
    .result_valid_o     (result_valid_o),
    .verdict_packet_id_o(verdict_packet_id_o),
    .verdict_drop_o     (verdict_drop_o),
    .entry_created_o    (entry_created_o),
    .table_full_o       (table_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the verdict of one request and updates the predicted table.
  // The first valid match wins; on a miss the lowest free slot is taken, and
  // when there is none the request is accepted and nothing is stored.
  function automatic verdict_t judge_packet(key_t key, logic redundant,
                                            logic [TimeW-1:0] now,
                                            logic [PidW-1:0] pid);
    int       hit;
    int       free_slot;
    verdict_t verdict;
    hit       = -1;
    free_slot = -1;
    verdict   = '{pid: pid, drop: 1'b0, created: 1'b0, full: 1'b0};
    for (int i = 0; i < Slots; i++) begin
      if (sender_valid[i]) begin
        if (hit < 0 && sender_key[i] == key) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        verdict.full = 1'b1;
      end else begin
        hit                       = free_slot;
        sender_valid[hit]         = 1'b1;
        sender_key[hit]           = key;
        sender_enabled[hit]       = redundant;
        sender_count              = sender_count + 1;
        verdict.created           = 1'b1;
      end
    end
    if (hit >= 0) begin
      sender_seen[hit] = now;
      if (redundant) sender_enabled[hit] = 1'b1;
      verdict.drop = !redundant && sender_enabled[hit];
    end
    return verdict;
  endfunction

  function automatic stim_row_t mk_row(logic [AddrW-1:0] source, logic [AddrW-1:0] group,
                                       logic [PortW-1:0] port, logic redundant,
                                       logic [TimeW-1:0] now, logic [PidW-1:0] pid,
                                       logic typed, logic drop, logic created,
                                       logic full);
    stim_row_t row;
    row.key       = '{source: source, group: group, port: port};
    row.redundant = redundant;
    row.now       = now;
    row.pid       = pid;
    row.typed     = typed;
    row.verdict   = '{pid: pid, drop: drop, created: created, full: full};
    return row;
  endfunction

  // All zeros, all ones or a random word, to push fields to their extremes.
  function automatic logic [31:0] corner_word();
    case ($urandom_range(2))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Most random requests reuse a stored key. Fresh keys are either wholly
  // random, built from corner values, or a stored key with a single bit
  // flipped, which checks that every bit of the key takes part in the match.
  function automatic key_t pick_key();
    key_t key;
    if (sender_count != 0 && $urandom_range(99) >= NewKeyPct) begin
      return sender_key[$urandom_range(sender_count - 1)];
    end
    key.source = $urandom;
    key.group  = $urandom;
    key.port   = 16'($urandom);
    case ($urandom_range(2))
      0: begin
        if (sender_count != 0) begin
          key = sender_key[$urandom_range(sender_count - 1)];
          case ($urandom_range(2))
            0:       key.source ^= 32'd1 << $urandom_range(AddrW - 1);
            1:       key.group  ^= 32'd1 << $urandom_range(AddrW - 1);
            default: key.port   ^= 16'd1 << $urandom_range(PortW - 1);
          endcase
        end
      end
      1: begin
        key.source = corner_word();
        key.group  = corner_word();
        key.port   = 16'(corner_word());
      end
      default: ;
    endcase
    return key;
  endfunction

  // Presents one request and waits until it is taken. The strobe is left high
  // after acceptance, so back-to-back requests never see start dropped and
  // raised within one time step; it is lowered only when a gap is inserted.
  task automatic issue_request(stim_row_t row);
    int unsigned gap;
    verdict_t    predicted;
    gap = 0;
    if (phase_idle_pct != 0 && $urandom_range(99) < phase_idle_pct)
      gap = $urandom_range(1, LongestGap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start              <= 1'b1;
    source_address_i   <= row.key.source;
    group_address_i    <= row.key.group;
    destination_port_i <= row.key.port;
    redundant_path_i   <= row.redundant;
    current_time_i     <= row.now;
    packet_id_i        <= row.pid;
    do @(posedge clk_i); while (busy);
    // The request was taken at this edge; the predictor must still see it
    // even when the expected verdict is typed into the table.
    predicted = judge_packet(row.key, row.redundant, row.now, row.pid);
    pending_verdicts.push_back(row.typed ? row.verdict : predicted);
  endtask

  // Verdict checker: each strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict for packet %h with no request outstanding", $time,
                 verdict_packet_id_o);
        fault_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_packet_id_o !== want.pid) begin
          $display("%0t: verdict_packet_id expected %h actual %h", $time, want.pid,
                   verdict_packet_id_o);
          fault_count++;
        end
        if (verdict_drop_o !== want.drop) begin
          $display("%0t: verdict_drop (packet %h) expected %b actual %b", $time, want.pid,
                   want.drop, verdict_drop_o);
          fault_count++;
        end
        if (entry_created_o !== want.created) begin
          $display("%0t: entry_created (packet %h) expected %b actual %b", $time, want.pid,
                   want.created, entry_created_o);
          fault_count++;
        end
        if (table_full_o !== want.full) begin
          $display("%0t: table_full (packet %h) expected %b actual %b", $time, want.pid,
                   want.full, table_full_o);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: a block that stops taking requests and stops giving verdicts
  // ends the run as a failure.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_pct [4];
    stim_row_t   row;
    phase_pct = '{0, 75, 31, 0};
    phase_idle_pct = 0;
    sender_count   = 0;
    for (int i = 0; i < Slots; i++) sender_valid[i] = 1'b0;

    rst_ni             <= 1'b0;
    start              <= 1'b0;
    source_address_i   <= '0;
    group_address_i    <= '0;
    destination_port_i <= '0;
    redundant_path_i   <= 1'b0;
    current_time_i     <= '0;
    packet_id_i        <= '0;

    // Directed table. The first six rows start from an empty table and can be
    // read off at a glance: insert with the mark clear, hits that accept, the
    // mark being set by a redundant-path request, then a drop. The remaining
    // rows probe near misses in each key field and are left to the predictor.
    directed_rows.push_back(mk_row('0, '0, '0, 1'b0, '0, '0, 1'b1, 1'b0, 1'b1, 1'b0));
    directed_rows.push_back(mk_row('0, '0, '0, 1'b0, '1, '1, 1'b1, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row('0, '0, '0, 1'b1, 32'd1, 32'd1, 1'b1, 1'b0, 1'b0,
                                   1'b0));
    directed_rows.push_back(mk_row('0, '0, '0, 1'b0, 32'd2, 32'd2, 1'b1, 1'b1, 1'b0,
                                   1'b0));
    directed_rows.push_back(mk_row('1, '1, '1, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b1,
                                   1'b0, 1'b1, 1'b0));
    directed_rows.push_back(mk_row('1, '1, '1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                                   1'b1, 1'b0, 1'b0));
    directed_rows.push_back(mk_row('1, '1, 16'hFFFE, 1'b0, 32'd7, 32'd7, 1'b0, 1'b0, 1'b0,
                                   1'b0));
    directed_rows.push_back(mk_row(32'd1, '0, '0, 1'b0, 32'd8, 32'd8, 1'b0, 1'b0, 1'b0,
                                   1'b0));
    directed_rows.push_back(mk_row('0, 32'h8000_0000, '0, 1'b0, 32'd9, 32'd9, 1'b0, 1'b0,
                                   1'b0, 1'b0));
    directed_rows.push_back(mk_row('0, '0, 16'h8000, 1'b1, 32'd10, 32'd10, 1'b0, 1'b0,
                                   1'b0, 1'b0));
    directed_rows.push_back(mk_row('0, '0, '0, 1'b0, 32'd11, 32'd11, 1'b0, 1'b0, 1'b0,
                                   1'b0));
    directed_rows.push_back(mk_row(32'h8000_0000, '1, 16'h0001, 1'b1, 32'd12, 32'd12, 1'b0,
                                   1'b0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(32'h8000_0000, '1, 16'h0001, 1'b1, 32'd13, 32'd13, 1'b0,
                                   1'b0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(32'h8000_0000, '1, 16'h0001, 1'b0, 32'd14, 32'd14, 1'b0,
                                   1'b0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 1'b0,
                                   32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 1'b1,
                                   32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 1'b0, 32'd17,
                                   32'd17, 1'b0, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 1'b1, 32'd18,
                                   32'd18, 1'b0, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(mk_row(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 1'b0, 32'd19,
                                   32'd19, 1'b0, 1'b0, 1'b0, 1'b0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) issue_request(directed_rows[i]);

    // Random requests in four idling phases. The table fills part way through
    // and the later requests with fresh keys then take the table-full path,
    // while reused keys keep producing hits, drops and accepts.
    for (int p = 0; p < 4; p++) begin
      phase_idle_pct = phase_pct[p];
      for (int n = 0; n < RandomItems / 4; n++) begin
        row.key       = pick_key();
        row.redundant = 1'($urandom_range(1));
        row.now       = $urandom;
        row.pid       = $urandom;
        row.typed     = 1'b0;
        row.verdict   = '0;
        issue_request(row);
      end
    end

    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    // Any stray verdict after the last expected one is caught here.
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/svt_pkg.sv
src/svt_ram.sv
src/svt_seq.sv
src/sender_table_verdict.sv
src/svt_checker.sv
tb/tb_sender_table_verdict.sv
